@@ rtl/dsu_pkg.sv @@
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants for the disjoint-set union-find engine.
// ----------------------------------------------------------------------------
package dsu_pkg;

   localparam int CMD_W  = 2;
   localparam int ELEM_W = 10;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [ELEM_W-1:0] elem_type;

   localparam cmd_type CMD_CLEAR = 2'd0;
   localparam cmd_type CMD_UNION = 2'd1;
   localparam cmd_type CMD_QUERY = 2'd2;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_WRAP,
      ST_CLEAR,
      ST_START,
      ST_FIND,
      ST_COMP,
      ST_LINK,
      ST_DONE
   } state_type;

endpackage

@@ rtl/dsu_mem.sv @@
// ----------------------------------------------------------------------------
// dsu_mem
// Parent store: one write port, one read port, registered read data.
// A read and a write to the same entry in one cycle return the old data.
// ----------------------------------------------------------------------------
module dsu_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dsu_wrap.sv @@
// ----------------------------------------------------------------------------
// dsu_wrap
// Reduces both element indices modulo ELEMENTS in two registered stages:
// reciprocal multiply for the quotient, then multiply-subtract.
// ----------------------------------------------------------------------------
module dsu_wrap import dsu_pkg::*; #(
   parameter int ELEMENTS = 1024
) (
   input  logic                        clock,
   input  logic                        load,
   input  elem_type                    elem_a,
   input  elem_type                    elem_b,
   output logic [$clog2(ELEMENTS)-1:0] index_a,
   output logic [$clog2(ELEMENTS)-1:0] index_b
);

   localparam int     IW    = $clog2(ELEMENTS);
   localparam int     SH    = ELEM_W + IW;
   localparam int     RW    = ELEM_W + 2;
   localparam int     MW    = ELEM_W + RW;
   localparam int     PW    = ELEM_W + IW + 1;
   localparam longint RECIP = ((64'd1 << SH) + ELEMENTS - 1) / ELEMENTS;

   elem_type          val_a_ff, val_b_ff;
   elem_type          quo_a_ff, quo_b_ff;
   elem_type          quo_a_in, quo_b_in;
   logic [MW-1:0]     prod_a, prod_b;
   elem_type          rem_a, rem_b;
   logic [IW-1:0]     index_a_ff, index_b_ff;
   logic [IW-1:0]     index_a_in, index_b_in;

   assign prod_a   = MW'(elem_a) * MW'(RECIP);
   assign prod_b   = MW'(elem_b) * MW'(RECIP);
   assign quo_a_in = ELEM_W'(prod_a >> SH);
   assign quo_b_in = ELEM_W'(prod_b >> SH);

   always_ff @(posedge clock) begin
      if (load) begin
         val_a_ff <= elem_a;
         val_b_ff <= elem_b;
         quo_a_ff <= quo_a_in;
         quo_b_ff <= quo_b_in;
      end
   end

   assign rem_a      = val_a_ff - ELEM_W'(PW'(quo_a_ff) * PW'(ELEMENTS));
   assign rem_b      = val_b_ff - ELEM_W'(PW'(quo_b_ff) * PW'(ELEMENTS));
   assign index_a_in = IW'(rem_a);
   assign index_b_in = IW'(rem_b);

   always_ff @(posedge clock) begin
      index_a_ff <= index_a_in;
      index_b_ff <= index_b_in;
   end

   assign index_a = index_a_ff;
   assign index_b = index_b_ff;

endmodule

@@ rtl/disjoint_set_union_find_top.sv @@
// ----------------------------------------------------------------------------
// disjoint_set_union_find_top
// Union-find engine with path compression over a single parent memory.
//
//   channel  dir   handshake            payload
//   req      in    req_valid/req_stall  req_command, req_elem_a, req_elem_b
//   rsp      out   rsp_valid/rsp_stall  rsp_same_set, rsp_root_a, rsp_root_b
//
// Union/query: each parent link walked in a root search costs one memory
// read to find it and one write to compress it.
// Clear: one parent entry rewritten per cycle.
// After reset a pass over all ELEMENTS entries rebuilds the store; req_stall is high.
// One transaction in flight; the result register lets the next request in
// while rsp_stall holds the previous result.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_top import dsu_pkg::*; #(
   parameter int ELEMENTS = 1024
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  cmd_type  req_command,
   input  elem_type req_elem_a,
   input  elem_type req_elem_b,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output logic     rsp_same_set,
   output elem_type rsp_root_a,
   output elem_type rsp_root_b
);

   localparam int IW = $clog2(ELEMENTS);
   localparam int SW = $clog2(ELEMENTS + 1);

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic          which_ff, which_in;
   logic [IW-1:0] node_ff, node_in;
   logic [IW-1:0] root_ff, root_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [IW-1:0] sweep_ff, sweep_in;
   logic [IW-1:0] root_a_ff, root_a_in;
   logic [IW-1:0] root_b_ff, root_b_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_same_ff;
   elem_type      rsp_root_a_ff, rsp_root_b_ff;

   logic          accept;
   logic          rsp_load;
   logic          is_find;
   logic          fin;
   logic [IW-1:0] fin_root;
   logic [IW-1:0] start;
   logic [SW-1:0] steps_inc;
   logic          limit_hit;
   logic [IW-1:0] index_a, index_b;

   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;

   dsu_wrap #(.ELEMENTS(ELEMENTS)) u_wrap (
      .clock   (clock),
      .load    (accept),
      .elem_a  (req_elem_a),
      .elem_b  (req_elem_b),
      .index_a (index_a),
      .index_b (index_b)
   );

   dsu_mem #(.DEPTH(ELEMENTS), .WIDTH(IW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign start     = which_ff ? index_b : index_a;
   assign steps_inc = steps_ff + SW'(1);
   assign limit_hit = (steps_inc == SW'(ELEMENTS));
   assign is_find   = (cmd_ff == CMD_UNION) || (cmd_ff == CMD_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         which_ff     <= 1'b0;
         steps_ff     <= '0;
         cmd_ff       <= CMD_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         which_ff     <= which_in;
         steps_ff     <= steps_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff   <= node_in;
      root_ff   <= root_in;
      root_a_ff <= root_a_in;
      root_b_ff <= root_b_in;
      if (rsp_load) begin
         rsp_same_ff   <= is_find && (root_a_ff == root_b_ff);
         rsp_root_a_ff <= is_find ? ELEM_W'(root_a_ff) : '0;
         rsp_root_b_ff <= is_find ? ELEM_W'(root_b_ff) : '0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      which_in  = which_ff;
      node_in   = node_ff;
      root_in   = root_ff;
      steps_in  = steps_ff;
      sweep_in  = sweep_ff;
      root_a_in = root_a_ff;
      root_b_in = root_b_ff;
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = sweep_ff;
      mem_raddr = node_ff;
      rsp_load  = 1'b0;
      fin       = 1'b0;
      fin_root  = root_ff;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + IW'(1);
            if (sweep_ff == IW'(ELEMENTS - 1)) begin
               sweep_in = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            which_in = 1'b0;
            if (req_valid) begin
               cmd_in = req_command;
               case (req_command)
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_UNION, CMD_QUERY: state_in = ST_WRAP;
                  default:              state_in = ST_DONE;
               endcase
            end
         end
         ST_WRAP: state_in = ST_START;
         ST_START: begin
            mem_raddr = start;
            node_in   = start;
            steps_in  = '0;
            state_in  = ST_FIND;
         end
         ST_FIND: begin
            if ((mem_rdata == node_ff) || limit_hit) begin
               if (start == mem_rdata) begin
                  fin      = 1'b1;
                  fin_root = mem_rdata;
               end else begin
                  mem_raddr = start;
                  node_in   = start;
                  steps_in  = '0;
                  root_in   = mem_rdata;
                  state_in  = ST_COMP;
               end
            end else begin
               mem_raddr = mem_rdata;
               node_in   = mem_rdata;
               steps_in  = steps_inc;
            end
         end
         ST_COMP: begin
            mem_we    = 1'b1;
            mem_waddr = node_ff;
            mem_wdata = root_ff;
            if ((mem_rdata != root_ff) && !limit_hit) begin
               mem_raddr = mem_rdata;
               node_in   = mem_rdata;
               steps_in  = steps_inc;
            end else begin
               fin      = 1'b1;
               fin_root = root_ff;
            end
         end
         ST_LINK: begin
            if ((cmd_ff == CMD_UNION) && (root_a_ff != root_b_ff)) begin
               mem_we = 1'b1;
               if (root_a_ff < root_b_ff) begin
                  mem_waddr = root_b_ff;
                  mem_wdata = root_a_ff;
               end else begin
                  mem_waddr = root_a_ff;
                  mem_wdata = root_b_ff;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (fin) begin
         if (!which_ff) begin
            root_a_in = fin_root;
            which_in  = 1'b1;
            state_in  = ST_START;
         end else begin
            root_b_in = fin_root;
            state_in  = ST_LINK;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_same_set = rsp_same_ff;
   assign rsp_root_a   = rsp_root_a_ff;
   assign rsp_root_b   = rsp_root_b_ff;

endmodule

@@ rtl/dsu_checker.sv @@
// ----------------------------------------------------------------------------
// dsu_checker
// Port-level checks for the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
module dsu_checker import dsu_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_stall,
   input logic     rsp_valid,
   input logic     rsp_stall,
   input logic     rsp_same_set,
   input elem_type rsp_root_a,
   input elem_type rsp_root_b
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_same_set)
         && $stable(rsp_root_a) && $stable(rsp_root_b))
      else $error("rsp changed while stalled");

   a_same_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_same_set |-> rsp_root_a == rsp_root_b)
      else $error("same_set with different roots");

   a_diff_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_same_set |->
         (rsp_root_a != rsp_root_b) || (rsp_root_a == '0 && rsp_root_b == '0))
      else $error("equal nonzero roots without same_set");

   // store rebuild after reset blocks requests, no stale result
   a_reset: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("not quiet after reset");

   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken back to back");

endmodule

bind disjoint_set_union_find_top dsu_checker u_dsu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_same_set (rsp_same_set),
   .rsp_root_a   (rsp_root_a),
   .rsp_root_b   (rsp_root_b)
);

@@ bench/disjoint_set_union_find_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disjoint_set_union_find_top_tb
// Self-checking bench for the union-find engine. A queue of union, query,
// clear and unused commands drives the request channel with random gaps. A
// shadow parent table, which also compresses paths, predicts the roots and
// the same-set flag of every transaction. Each response is checked against
// the oldest prediction while the response side stalls at random.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_top_tb;
   import dsu_pkg::*;

   localparam int      ELEMENTS     = 1024;
   localparam int      RANDOM_ITEMS = 850;
   localparam int      IDLE_LIMIT   = 20000;
   localparam int      DRAIN_CYCLES = 64;
   localparam int      HOLD_AT      = 300;
   localparam int      HOLD_CYCLES  = 250;
   localparam cmd_type CMD_UNUSED   = 2'd3;

   typedef struct {
      cmd_type  command;
      elem_type elem_a;
      elem_type elem_b;
      int       gap;
      bit       drain;
   } request_item_type;

   typedef struct {
      logic     same_set;
      elem_type root_a;
      elem_type root_b;
   } root_pair_type;

   logic     clock        = 1'b0;
   logic     reset        = 1'b1;
   logic     req_valid    = 1'b0;
   logic     req_stall;
   cmd_type  req_command  = CMD_CLEAR;
   elem_type req_elem_a   = '0;
   elem_type req_elem_b   = '0;
   logic     rsp_valid;
   logic     rsp_stall    = 1'b0;
   logic     rsp_same_set;
   elem_type rsp_root_a;
   elem_type rsp_root_b;

   request_item_type pending_requests[$];
   root_pair_type    expected_roots[$];
   elem_type         parent_mirror[ELEMENTS];
   int               mismatch_count = 0;
   int               req_count      = 0;
   bit               req_accepted   = 1'b0;
   int               window_base    = 0;
   int               window_span    = 63;

   disjoint_set_union_find_top #(.ELEMENTS(ELEMENTS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_elem_a  (req_elem_a),
      .req_elem_b  (req_elem_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_same_set(rsp_same_set),
      .rsp_root_a  (rsp_root_a),
      .rsp_root_b  (rsp_root_b)
   );

   always #10 clock = ~clock;

   // ---------------- shadow parent table ----------------
   function automatic void clear_mirror();
      for (int i = 0; i < ELEMENTS; i++) begin
         parent_mirror[i] = elem_type'(i);
      end
   endfunction

   function automatic elem_type find_and_compress(elem_type start);
      elem_type node;
      elem_type up;
      elem_type found;
      int       steps;
      node  = start;
      steps = 0;
      while (steps < ELEMENTS) begin
         up = parent_mirror[node];
         if (up == node) break;
         node = up;
         steps++;
      end
      found = node;
      node  = start;
      steps = 0;
      while (node != found && steps < ELEMENTS) begin
         up                  = parent_mirror[node];
         parent_mirror[node] = found;
         node                = up;
         steps++;
      end
      return found;
   endfunction

   function automatic root_pair_type predict_roots(cmd_type command, elem_type a, elem_type b);
      root_pair_type res;
      res = '{same_set: 1'b0, root_a: '0, root_b: '0};
      case (command)
         CMD_CLEAR: begin
            clear_mirror();
         end
         CMD_UNION, CMD_QUERY: begin
            res.root_a   = find_and_compress(a);
            res.root_b   = find_and_compress(b);
            res.same_set = (res.root_a == res.root_b);
            if (command == CMD_UNION && !res.same_set) begin
               if (res.root_a < res.root_b) parent_mirror[res.root_b] = res.root_a;
               else                         parent_mirror[res.root_a] = res.root_b;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic elem_type pick_elem();
      if ($urandom_range(0, 99) < 85)
         return elem_type'(window_base + $urandom_range(0, window_span));
      return elem_type'($urandom);
   endfunction

   function automatic void new_window();
      int r;
      r           = $urandom_range(0, 2);
      window_base = $urandom_range(0, ELEMENTS - 1);
      window_span = (r == 0) ? 15 : (r == 1) ? 63 : 255;
   endfunction

   task automatic add_request(cmd_type command, elem_type a, elem_type b, int gap, bit drain);
      request_item_type item;
      item = '{command: command, elem_a: a, elem_b: b, gap: gap, drain: drain};
      pending_requests.insert(pending_requests.size(), item);
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("ERROR @%0t: %s", $time, what);
   endtask

   // ---------------- driver ----------------
   int gap_left  = 0;
   bit gap_armed = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
         gap_armed = 1'b0;
      end else if (!(req_valid && !req_accepted)) begin
         if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            if (!gap_armed) begin
               gap_left  = pending_requests[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests[0].drain && expected_roots.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               req_command <= pending_requests[0].command;
               req_elem_a  <= pending_requests[0].elem_a;
               req_elem_b  <= pending_requests[0].elem_b;
               req_valid   <= 1'b1;
               void'(pending_requests.pop_front());
               gap_armed = 1'b0;
            end
         end
      end
   end

   // ---------------- response-side stall ----------------
   int hold_left  = 0;
   bit hold_done  = 1'b0;
   int stall_left = 0;
   int quiet_left = 0;

   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && req_count >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (quiet_left > 0) begin
         quiet_left--;
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            quiet_left = $urandom_range(30, 120);
            rsp_stall <= 1'b0;
         end else if (r < 20) begin
            stall_left = gap_length();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- monitor, checker and watchdog ----------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      root_pair_type exp_roots;
      bit            rsp_fire;
      if (reset) begin
         req_accepted = 1'b0;
         idle_cycles  = 0;
         clear_mirror();
      end else begin
         req_accepted = req_valid && !req_stall;
         rsp_fire     = rsp_valid && !rsp_stall;
         if (rsp_fire) begin
            if (expected_roots.size() == 0) begin
               report_mismatch("response transaction with nothing expected");
            end else begin
               exp_roots = expected_roots.pop_front();
               if (rsp_same_set !== exp_roots.same_set)
                  report_mismatch($sformatf("same_set got %0b exp %0b",
                                            rsp_same_set, exp_roots.same_set));
               if (rsp_root_a !== exp_roots.root_a)
                  report_mismatch($sformatf("root_a got %0d exp %0d",
                                            rsp_root_a, exp_roots.root_a));
               if (rsp_root_b !== exp_roots.root_b)
                  report_mismatch($sformatf("root_b got %0d exp %0d",
                                            rsp_root_b, exp_roots.root_b));
            end
         end
         if (req_accepted) begin
            expected_roots.insert(expected_roots.size(),
                                  predict_roots(req_command, req_elem_a, req_elem_b));
            req_count++;
         end
         idle_cycles = (req_accepted || rsp_fire) ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR @%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------- sequence ----------------
   initial begin
      int      r;
      int      burst_left;
      int      gap;
      cmd_type command;

      // directed
      add_request(CMD_QUERY,  10'd0,    10'd1023, gap_length(), 1'b0);
      add_request(CMD_UNION,  10'd1023, 10'd0,    gap_length(), 1'b0);
      add_request(CMD_QUERY,  10'd1023, 10'd0,    gap_length(), 1'b0);
      add_request(CMD_UNION,  10'd0,    10'd0,    gap_length(), 1'b0);
      add_request(CMD_UNION,  10'd1023, 10'd0,    gap_length(), 1'b0);
      add_request(CMD_QUERY,  10'd1023, 10'd1023, gap_length(), 1'b0);
      add_request(CMD_UNUSED, 10'd1023, 10'd1023, gap_length(), 1'b0);
      add_request(CMD_UNUSED, 10'h2AA,  10'h155,  gap_length(), 1'b0);
      add_request(CMD_UNION,  10'd5,    10'd9,    gap_length(), 1'b0);
      add_request(CMD_UNION,  10'd700,  10'd3,    gap_length(), 1'b0);
      // descending unions build one long chain, then walk and compress it
      for (int k = 600; k > 590; k--) begin
         add_request(CMD_UNION, elem_type'(k), elem_type'(k - 1), gap_length(), 1'b0);
      end
      add_request(CMD_QUERY,  10'd600,  10'd590,  gap_length(), 1'b0);
      add_request(CMD_QUERY,  10'd600,  10'd595,  gap_length(), 1'b0);
      add_request(CMD_CLEAR,  10'h3FF,  10'h3FF,  gap_length(), 1'b0);
      add_request(CMD_QUERY,  10'd1023, 10'd0,    gap_length(), 1'b0);

      // random
      burst_left = 0;
      new_window();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 2)       command = CMD_CLEAR;
         else if (r < 4)  command = CMD_UNUSED;
         else if (r < 52) command = CMD_UNION;
         else             command = CMD_QUERY;
         if (burst_left > 0) begin
            gap = 0;
            burst_left--;
         end else begin
            gap = gap_length();
            if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
         end
         add_request(command, pick_elem(), pick_elem(), gap, (i % 120) == 0);
         if (command == CMD_CLEAR || (i % 150) == 149) new_window();
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_roots.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
